// File: rtl/fbpa_pkg.sv
// Shared constants, payload types and codes for the fixed block pool allocator.
package fbpa_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int BLK_W        = $clog2(MAX_BLOCKS);
  localparam int LINK_W       = $clog2(MAX_BLOCKS + 1);

  // Field and register widths.
  localparam int SIZE_W    = 13;
  localparam int COUNT_W   = 7;
  localparam int REQ_W     = 16;
  localparam int OFFSET_W  = 19;
  localparam int STATUS_W  = 3;
  localparam int STRIDE_W  = 13;
  localparam int SIZE_MAX  = 4096;

  // Register reset values.
  localparam int SIZE_RESET  = 64;
  localparam int COUNT_RESET = 64;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // The null link value marks the end of the free list.
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

  // Commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_OFFSET = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC  = 3'd4;

  typedef struct packed {
    logic                cmd;
    logic [REQ_W-1:0]    request_size;
    logic [OFFSET_W-1:0] data_offset;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] granted_offset;
  } rsp_t;

endpackage

// File: rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: free list, sequencer and offset divider.
//
// The block hands out and takes back equal-sized blocks of a pool through a LIFO
// free list. Requests arrive on the req channel (valid/ready) and every request
// produces exactly one transfer on the rsp channel (valid/ready) carrying ok, a
// status code and, for a successful allocate, the data offset of the block.
// An allocate passes through S_ALLOC and S_DONE before its result is offered. A free
// runs the offset through a restoring divider, one quotient bit a cycle, then
// through S_FREE and S_DONE; a free whose offset lies below the header skips
// the divider and goes straight to S_DONE.
// req_ready is high only while the sequencer is idle, so the block works on one
// request at a time and takes the next only after the last result is loaded.
// Results sit in an output register; the sequencer goes back to idle once its
// result is loaded, so a new request can be taken while the previous result still
// waits for the receiver. If the receiver stalls longer, the next result waits in
// the sequencer and req_ready stays low until the output register drains.
// The APB port holds block_size (address 0) and block_count (address 4). Any
// write rebuilds the free list: all blocks free, block 0 first. Synchronous reset
// does the same with both registers at their reset values. The list is rebuilt at
// once through per-entry valid bits, so no clearing pass is needed.
module fixed_block_pool_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  fbpa_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output fbpa_pkg::rsp_t                rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbpa_pkg::APB_AW-1:0]   paddr,
  input  logic [fbpa_pkg::APB_DW-1:0]   pwdata,
  output logic [fbpa_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam int DIV_STEPS = fbpa_pkg::OFFSET_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Control state.
  logic [2:0]                         state;
  logic [fbpa_pkg::SIZE_W-1:0]        block_size;
  logic [fbpa_pkg::COUNT_W-1:0]       block_count;
  logic [fbpa_pkg::LINK_W-1:0]        head;
  logic [fbpa_pkg::MAX_BLOCKS-1:0]    nf_valid;
  logic [fbpa_pkg::MAX_BLOCKS-1:0]    marks;

  // Datapath registers.
  fbpa_pkg::req_t                     req_q;
  fbpa_pkg::rsp_t                     res;
  logic [fbpa_pkg::OFFSET_W-1:0]      quo;
  logic [fbpa_pkg::STRIDE_W-1:0]      rem;
  logic [CNT_W-1:0]                   cnt;

  // Link memory, one entry per block.
  logic [fbpa_pkg::LINK_W-1:0]        nf_mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::LINK_W-1:0]        nf_rdata;
  logic                               nf_we;
  logic [fbpa_pkg::BLK_W-1:0]         nf_waddr;
  logic [fbpa_pkg::LINK_W-1:0]        nf_wdata;

  logic                               cfg_wr;
  logic                               req_xfer;
  logic                               rsp_load;
  logic [fbpa_pkg::SIZE_W-1:0]        size_eff;
  logic [fbpa_pkg::LINK_W-1:0]        count_eff;
  logic [fbpa_pkg::STRIDE_W-1:0]      stride;
  logic [fbpa_pkg::BLK_W-1:0]         head_idx;
  logic [fbpa_pkg::LINK_W-1:0]        head_inc;
  logic [fbpa_pkg::LINK_W-1:0]        link;
  logic                               too_large;
  logic                               alloc_ok;
  logic [fbpa_pkg::OFFSET_W-1:0]      granted;
  logic [fbpa_pkg::STRIDE_W:0]        trial;
  logic                               trial_ge;
  logic [fbpa_pkg::BLK_W-1:0]         quo_idx;
  logic                               offset_bad;
  logic                               free_ok;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign req_ready = (state == S_IDLE);
  assign req_xfer = req_valid && req_ready;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    case (paddr[2])
      fbpa_pkg::REG_BLOCK_SIZE:  prdata = fbpa_pkg::APB_DW'(block_size);
      fbpa_pkg::REG_BLOCK_COUNT: prdata = fbpa_pkg::APB_DW'(block_count);
      default:                   prdata = '0;
    endcase
  end

  // Out-of-range register values are clamped into the legal range.
  always_comb begin
    if (block_size == '0) begin
      size_eff = fbpa_pkg::SIZE_W'(1);
    end else if (32'(block_size) > fbpa_pkg::SIZE_MAX) begin
      size_eff = fbpa_pkg::SIZE_W'(fbpa_pkg::SIZE_MAX);
    end else begin
      size_eff = block_size;
    end
    if (block_count == '0) begin
      count_eff = fbpa_pkg::LINK_W'(1);
    end else if (32'(block_count) > fbpa_pkg::MAX_BLOCKS) begin
      count_eff = fbpa_pkg::LINK_W'(fbpa_pkg::MAX_BLOCKS);
    end else begin
      count_eff = fbpa_pkg::LINK_W'(block_count);
    end
  end

  assign stride = fbpa_pkg::STRIDE_W'(size_eff) + fbpa_pkg::STRIDE_W'(fbpa_pkg::HEADER_BYTES);

  // An entry never written since the last rebuild holds its initial link.
  assign head_idx = head[fbpa_pkg::BLK_W-1:0];
  assign head_inc = fbpa_pkg::LINK_W'(head_idx) + fbpa_pkg::LINK_W'(1);
  assign link     = nf_valid[head_idx] ? nf_rdata
                  : ((head_inc < count_eff) ? head_inc : fbpa_pkg::NULL_LINK);

  assign too_large = req_q.request_size > fbpa_pkg::REQ_W'(size_eff);
  assign alloc_ok  = !too_large && (head != fbpa_pkg::NULL_LINK);
  assign granted   = fbpa_pkg::OFFSET_W'(head_idx) * fbpa_pkg::OFFSET_W'(stride)
                   + fbpa_pkg::OFFSET_W'(fbpa_pkg::HEADER_BYTES);

  // One restoring division step per cycle.
  assign trial    = {rem, quo[fbpa_pkg::OFFSET_W-1]};
  assign trial_ge = trial >= (fbpa_pkg::STRIDE_W+1)'(stride);

  assign quo_idx    = quo[fbpa_pkg::BLK_W-1:0];
  assign offset_bad = (rem != '0) || (quo >= fbpa_pkg::OFFSET_W'(count_eff));
  assign free_ok    = !offset_bad && marks[quo_idx];

  always_comb begin
    nf_we    = 1'b0;
    nf_waddr = head_idx;
    nf_wdata = fbpa_pkg::NULL_LINK;
    case (state)
      S_ALLOC: begin
        nf_we = alloc_ok;
      end
      S_FREE: begin
        nf_we    = free_ok;
        nf_waddr = quo_idx;
        nf_wdata = head;
      end
      default: begin
        nf_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nf_we) begin
      nf_mem[nf_waddr] <= nf_wdata;
    end
    nf_rdata <= nf_mem[head_idx];
  end

  // Sequencer and free-list control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_size  <= fbpa_pkg::SIZE_W'(fbpa_pkg::SIZE_RESET);
      block_count <= fbpa_pkg::COUNT_W'(fbpa_pkg::COUNT_RESET);
      head        <= '0;
      nf_valid    <= '0;
      marks       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2] == fbpa_pkg::REG_BLOCK_SIZE) begin
          block_size <= pwdata[fbpa_pkg::SIZE_W-1:0];
        end else begin
          block_count <= pwdata[fbpa_pkg::COUNT_W-1:0];
        end
        head     <= '0;
        nf_valid <= '0;
        marks    <= '0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.cmd == fbpa_pkg::CMD_ALLOC) begin
              state <= S_ALLOC;
            end else if (req.data_offset < fbpa_pkg::OFFSET_W'(fbpa_pkg::HEADER_BYTES)) begin
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_ALLOC: begin
          if (alloc_ok) begin
            head               <= link;
            nf_valid[head_idx] <= 1'b1;
            marks[head_idx]    <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_FREE;
          end
        end
        S_FREE: begin
          if (free_ok) begin
            head              <= fbpa_pkg::LINK_W'(quo_idx);
            nf_valid[quo_idx] <= 1'b1;
            marks[quo_idx]    <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: request capture, divider and result formation.
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_q <= req;
      quo   <= req.data_offset - fbpa_pkg::OFFSET_W'(fbpa_pkg::HEADER_BYTES);
      rem   <= '0;
      cnt   <= CNT_W'(DIV_STEPS - 1);
      res   <= '{ok: 1'b0, status: fbpa_pkg::STATUS_BAD_OFFSET, granted_offset: '0};
    end
    case (state)
      S_ALLOC: begin
        if (too_large) begin
          res <= '{ok: 1'b0, status: fbpa_pkg::STATUS_TOO_LARGE, granted_offset: '0};
        end else if (!alloc_ok) begin
          res <= '{ok: 1'b0, status: fbpa_pkg::STATUS_EMPTY, granted_offset: '0};
        end else begin
          res <= '{ok: 1'b1, status: fbpa_pkg::STATUS_OK, granted_offset: granted};
        end
      end
      S_DIV: begin
        quo <= {quo[fbpa_pkg::OFFSET_W-2:0], trial_ge};
        rem <= trial_ge ? fbpa_pkg::STRIDE_W'(trial - (fbpa_pkg::STRIDE_W+1)'(stride))
                        : trial[fbpa_pkg::STRIDE_W-1:0];
        cnt <= cnt - CNT_W'(1);
      end
      S_FREE: begin
        if (offset_bad) begin
          res <= '{ok: 1'b0, status: fbpa_pkg::STATUS_BAD_OFFSET, granted_offset: '0};
        end else if (!free_ok) begin
          res <= '{ok: 1'b0, status: fbpa_pkg::STATUS_NOT_ALLOC, granted_offset: '0};
        end else begin
          res <= '{ok: 1'b1, status: fbpa_pkg::STATUS_OK, granted_offset: '0};
        end
      end
      default: begin
      end
    endcase
    if (rsp_load) begin
      rsp <= res;
    end
  end

endmodule

// File: rtl/fbpa_checker.sv
// Port-level assertions for the fixed block pool allocator, bound to the top level.
module fbpa_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input fbpa_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input fbpa_pkg::rsp_t rsp
);

  // A waiting request keeps its valid and its payload.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

  // A stalled result holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // The ok flag agrees with the status code.
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.ok == (rsp.status == fbpa_pkg::STATUS_OK)))
    else $error("ok flag disagrees with status");

  // A refused request grants no offset.
  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.granted_offset == '0)
    else $error("refused request carries an offset");

  // Only one request is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
